### rtl/bz_pkg.sv
package bz_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int COORD_W        = 32;
    localparam int T_W            = 17;
    localparam int PC_W           = 5;
    localparam int PROD_W         = COORD_W + 1 + T_W + 1;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam int REG_IDX_W      = APB_ADDR_W - 2;

    localparam logic [T_W-1:0]       T_ONE           = T_W'(65536);
    localparam logic [PC_W-1:0]      PC_RESET        = PC_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = REG_IDX_W'(0);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_STREAM,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic pt_we;
        logic eval_start;
        logic rd_scratch;
        logic load_a;
        logic mul_en;
        logic wr_en;
        logic res_lerp;
        logic res_raw;
    } dp_cmd_t;

endpackage

### rtl/bz_lane.sv
module bz_lane #(
    parameter int MAX_POINTS = bz_pkg::MAX_POINTS_DEF,
    parameter int AW         = $clog2(MAX_POINTS)
) (
    input  logic                              clk,
    input  bz_pkg::dp_cmd_t                   cmd,
    input  logic [bz_pkg::T_W-1:0]            t_val,
    input  logic [AW-1:0]                     rd_addr,
    input  logic [AW-1:0]                     wr_addr,
    input  logic [AW-1:0]                     pt_addr,
    input  logic signed [bz_pkg::COORD_W-1:0] pt_data,
    output logic signed [bz_pkg::COORD_W-1:0] result
);

    localparam int CW = bz_pkg::COORD_W;
    localparam int PW = bz_pkg::PROD_W;

    logic signed [CW-1:0] ctrl_mem [MAX_POINTS];
    logic signed [CW-1:0] scr_mem [MAX_POINTS];

    logic signed [CW-1:0] rd_ctrl_reg;
    logic signed [CW-1:0] rd_scr_reg;
    logic                 src_reg;
    logic signed [CW-1:0] a_reg;
    logic signed [CW-1:0] a_hold_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [CW-1:0] result_reg;

    logic signed [CW-1:0] rdata;
    logic signed [CW:0]   diff;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-16-1:0] sum;

    assign rdata     = src_reg ? rd_scr_reg : rd_ctrl_reg;
    assign diff      = $signed({rdata[CW-1], rdata}) - $signed({a_reg[CW-1], a_reg});
    assign prod_next = diff * $signed({1'b0, t_val});
    assign sum       = $signed({{(PW-16-CW){a_hold_reg[CW-1]}}, a_hold_reg})
                       + $signed(prod_reg[PW-1:16]);

    always_ff @(posedge clk)
    begin
        if (cmd.pt_we)
        begin
            ctrl_mem[pt_addr] <= pt_data;
        end
        if (cmd.wr_en)
        begin
            scr_mem[wr_addr] <= sum[CW-1:0];
        end
        rd_ctrl_reg <= ctrl_mem[rd_addr];
        rd_scr_reg  <= scr_mem[rd_addr];
        src_reg     <= cmd.rd_scratch;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_a)
        begin
            a_reg <= rdata;
        end
        else if (cmd.mul_en)
        begin
            a_reg      <= rdata;
            a_hold_reg <= a_reg;
            prod_reg   <= prod_next;
        end
        if (cmd.res_lerp)
        begin
            result_reg <= sum[CW-1:0];
        end
        else if (cmd.res_raw)
        begin
            result_reg <= rdata;
        end
    end

    assign result = result_reg;

endmodule

### rtl/bz_datapath.sv
module bz_datapath #(
    parameter int MAX_POINTS = bz_pkg::MAX_POINTS_DEF,
    parameter int AW         = $clog2(MAX_POINTS)
) (
    input  logic                              clk,
    input  bz_pkg::dp_cmd_t                   cmd,
    input  logic [AW-1:0]                     rd_addr,
    input  logic [AW-1:0]                     wr_addr,
    input  logic [3:0]                        point_index,
    input  logic signed [bz_pkg::COORD_W-1:0] coord_x,
    input  logic signed [bz_pkg::COORD_W-1:0] coord_y,
    input  logic signed [bz_pkg::COORD_W-1:0] coord_z,
    input  logic [bz_pkg::T_W-1:0]            param_t,
    output logic signed [bz_pkg::COORD_W-1:0] curve_x,
    output logic signed [bz_pkg::COORD_W-1:0] curve_y,
    output logic signed [bz_pkg::COORD_W-1:0] curve_z
);

    logic [bz_pkg::T_W-1:0] t_reg;
    logic [AW-1:0]          pt_addr;

    assign pt_addr = AW'(point_index);

    // Parameters above one are clamped to exactly one.
    always_ff @(posedge clk)
    begin
        if (cmd.eval_start)
        begin
            t_reg <= (param_t > bz_pkg::T_ONE) ? bz_pkg::T_ONE : param_t;
        end
    end

    bz_lane #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_lane_x (
        .clk     (clk),
        .cmd     (cmd),
        .t_val   (t_reg),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .pt_addr (pt_addr),
        .pt_data (coord_x),
        .result  (curve_x)
    );

    bz_lane #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_lane_y (
        .clk     (clk),
        .cmd     (cmd),
        .t_val   (t_reg),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .pt_addr (pt_addr),
        .pt_data (coord_y),
        .result  (curve_y)
    );

    bz_lane #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_lane_z (
        .clk     (clk),
        .cmd     (cmd),
        .t_val   (t_reg),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .pt_addr (pt_addr),
        .pt_data (coord_z),
        .result  (curve_z)
    );

endmodule

### rtl/bz_ctrl.sv
module bz_ctrl #(
    parameter int MAX_POINTS = bz_pkg::MAX_POINTS_DEF,
    parameter int AW         = $clog2(MAX_POINTS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    kind,
    input  logic [3:0]              point_index,
    input  logic [bz_pkg::PC_W-1:0] point_count,
    output logic                    busy,
    output logic                    done,
    output bz_pkg::dp_cmd_t         cmd,
    output logic [AW-1:0]           rd_addr,
    output logic [AW-1:0]           wr_addr
);

    localparam int CW = $clog2(MAX_POINTS + 1);

    bz_pkg::state_t state_reg, state_next;

    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] j_reg, j_next;

    logic          s1_load_reg, s1_lerp_reg, s1_raw_reg, s1_final_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s2_lerp_reg, s2_final_reg;
    logic [AW-1:0] s2_addr_reg;
    logic          done_reg;

    logic          is_load, is_lerp, is_raw, is_final;
    logic [AW-1:0] is_addr;
    logic [CW-1:0] n_clamped;
    logic          last_pass;
    logic          pipe_empty;

    always_comb
    begin
        if (point_count == '0)
        begin
            n_clamped = CW'(1);
        end
        else if (32'(point_count) > MAX_POINTS)
        begin
            n_clamped = CW'(MAX_POINTS);
        end
        else
        begin
            n_clamped = CW'(point_count);
        end
    end

    assign last_pass  = (n_reg == CW'(1)) || (r_reg == n_reg - CW'(1));
    assign pipe_empty = !(s1_load_reg || s1_lerp_reg || s1_raw_reg || s2_lerp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bz_pkg::ST_IDLE;
            n_reg        <= '0;
            r_reg        <= '0;
            j_reg        <= '0;
            s1_load_reg  <= 1'b0;
            s1_lerp_reg  <= 1'b0;
            s1_raw_reg   <= 1'b0;
            s1_final_reg <= 1'b0;
            s1_addr_reg  <= '0;
            s2_lerp_reg  <= 1'b0;
            s2_final_reg <= 1'b0;
            s2_addr_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            r_reg        <= r_next;
            j_reg        <= j_next;
            s1_load_reg  <= is_load;
            s1_lerp_reg  <= is_lerp;
            s1_raw_reg   <= is_raw;
            s1_final_reg <= is_final;
            s1_addr_reg  <= is_addr;
            s2_lerp_reg  <= s1_lerp_reg;
            s2_final_reg <= s1_final_reg;
            s2_addr_reg  <= s1_addr_reg;
            done_reg     <= s1_raw_reg || (s2_lerp_reg && s2_final_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        r_next         = r_reg;
        j_next         = j_reg;
        is_load        = 1'b0;
        is_lerp        = 1'b0;
        is_raw         = 1'b0;
        is_final       = 1'b0;
        is_addr        = '0;
        rd_addr        = '0;
        cmd.pt_we      = 1'b0;
        cmd.eval_start = 1'b0;
        cmd.rd_scratch = (r_reg != CW'(1));
        cmd.load_a     = s1_load_reg;
        cmd.mul_en     = s1_lerp_reg;
        cmd.res_raw    = s1_raw_reg;
        cmd.wr_en      = s2_lerp_reg;
        cmd.res_lerp   = s2_lerp_reg && s2_final_reg;

        case (state_reg)
            bz_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == bz_pkg::KIND_WRITE)
                    begin
                        cmd.pt_we = (32'(point_index) < MAX_POINTS);
                    end
                    else
                    begin
                        cmd.eval_start = 1'b1;
                        n_next         = n_clamped;
                        r_next         = CW'(1);
                        state_next     = bz_pkg::ST_LOAD;
                    end
                end
            end

            bz_pkg::ST_LOAD:
            begin
                rd_addr = '0;
                j_next  = CW'(1);
                if (n_reg == CW'(1))
                begin
                    is_raw     = 1'b1;
                    state_next = bz_pkg::ST_DRAIN;
                end
                else
                begin
                    is_load    = 1'b1;
                    state_next = bz_pkg::ST_STREAM;
                end
            end

            bz_pkg::ST_STREAM:
            begin
                rd_addr  = j_reg[AW-1:0];
                is_lerp  = 1'b1;
                is_addr  = AW'(j_reg - CW'(1));
                is_final = (r_reg == n_reg - CW'(1));
                if (j_reg == n_reg - r_reg)
                begin
                    state_next = bz_pkg::ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end

            bz_pkg::ST_DRAIN:
            begin
                // A pass must have written all entries before the next one reads them.
                if (pipe_empty)
                begin
                    if (last_pass)
                    begin
                        state_next = bz_pkg::ST_IDLE;
                    end
                    else
                    begin
                        r_next     = r_reg + CW'(1);
                        state_next = bz_pkg::ST_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = bz_pkg::ST_IDLE;
            end
        endcase
    end

    assign wr_addr      = s2_addr_reg;
    assign busy         = (state_reg != bz_pkg::ST_IDLE);
    assign done         = done_reg;

endmodule

### rtl/bezier_de_casteljau_eval.sv
// Three-dimensional Bezier curve evaluator using de Casteljau reduction.
// Items arrive on the command channel: a transfer happens when start is high
// and busy is low. A write item (kind low) stores coord_x, coord_y and coord_z
// into slot point_index in the same cycle and produces no result; busy stays
// low. An evaluate item (kind high) clamps param_t to one and reduces the
// first n = point_count control points (clamped to 1..MAX_POINTS).
// The result appears on curve_x, curve_y and curve_z for exactly one cycle
// with done high; the receiver cannot stall it. busy falls in the cycle
// after done. Each pass streams one interpolation per cycle through the
// per-axis multiplier and then waits for the scratch memory writes to land.
// The point_count register sits at APB address 0 and resets to 4.
// Reset clears the controller; the control point memories are not cleared.
module bezier_de_casteljau_eval #(
    parameter int MAX_POINTS = bz_pkg::MAX_POINTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bz_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [bz_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [bz_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                 pready,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 kind,
    input  logic [3:0]                           point_index,
    input  logic signed [bz_pkg::COORD_W-1:0]    coord_x,
    input  logic signed [bz_pkg::COORD_W-1:0]    coord_y,
    input  logic signed [bz_pkg::COORD_W-1:0]    coord_z,
    input  logic [bz_pkg::T_W-1:0]               param_t,
    output logic                                 done,
    output logic signed [bz_pkg::COORD_W-1:0]    curve_x,
    output logic signed [bz_pkg::COORD_W-1:0]    curve_y,
    output logic signed [bz_pkg::COORD_W-1:0]    curve_z
);

    localparam int AW = $clog2(MAX_POINTS);

    logic [bz_pkg::PC_W-1:0] point_count_reg;
    logic                    reg_sel;
    bz_pkg::dp_cmd_t         cmd;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[bz_pkg::APB_ADDR_W-1:2] == bz_pkg::REG_POINT_COUNT);
    assign prdata  = reg_sel ? bz_pkg::APB_DATA_W'(point_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= bz_pkg::PC_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            point_count_reg <= pwdata[bz_pkg::PC_W-1:0];
        end
    end

    bz_ctrl #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .point_index (point_index),
        .point_count (point_count_reg),
        .busy        (busy),
        .done        (done),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr)
    );

    bz_datapath #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .point_index (point_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .param_t     (param_t),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .curve_z     (curve_z)
    );

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("Result strobe outside an evaluation.");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe held for more than one cycle.");

    a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == bz_pkg::KIND_EVAL) |=> busy)
        else $error("Evaluate transfer did not start the controller.");

    a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("Evaluation finished without a result.");

endmodule

### tb/bezier_de_casteljau_eval_tb.sv
module bezier_de_casteljau_eval_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PTS = bz_pkg::MAX_POINTS_DEF;
    localparam int N_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int DRAIN_CYCLES = 200;
    localparam int AW_TB = bz_pkg::APB_ADDR_W;
    localparam int DW_TB = bz_pkg::APB_DATA_W;
    localparam int CW_TB = bz_pkg::COORD_W;
    localparam int TW_TB = bz_pkg::T_W;
    localparam int PW_TB = bz_pkg::PC_W;
    localparam logic [AW_TB-1:0] PC_ADDR = AW_TB'({bz_pkg::REG_POINT_COUNT, 2'b00});

    typedef struct packed {
        logic signed [CW_TB-1:0] x;
        logic signed [CW_TB-1:0] y;
        logic signed [CW_TB-1:0] z;
    } point_t;

    typedef struct packed {
        logic             kind;
        logic [3:0]       slot;
        point_t           pt;
        logic [TW_TB-1:0] t;
    } cmd_t;

    typedef struct packed {
        cmd_t   cmd;
        logic   known;
        point_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [AW_TB-1:0] paddr;
    logic [DW_TB-1:0] pwdata;
    logic [DW_TB-1:0] prdata;
    logic pready;
    logic start;
    logic busy;
    logic kind;
    logic [3:0] point_index;
    logic signed [CW_TB-1:0] coord_x;
    logic signed [CW_TB-1:0] coord_y;
    logic signed [CW_TB-1:0] coord_z;
    logic [TW_TB-1:0] param_t;
    logic done;
    logic signed [CW_TB-1:0] curve_x;
    logic signed [CW_TB-1:0] curve_y;
    logic signed [CW_TB-1:0] curve_z;

    logic signed [CW_TB-1:0] ctrl_pts [3][MAX_PTS];
    logic [PW_TB-1:0] pc_setting;
    point_t pending_points [$];
    dir_row_t dir_rows [$];
    int n_errors = 0;
    int n_writes = 0;
    int n_evals = 0;
    int n_results = 0;

    bezier_de_casteljau_eval u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .point_index (point_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .param_t     (param_t),
        .done        (done),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .curve_z     (curve_z)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("bezier_de_casteljau_eval regression: fail");
        $finish;
    end

    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= 10)
        begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    // The product is shifted arithmetically, so the step rounds toward minus infinity.
    function automatic logic signed [CW_TB-1:0] lerp_floor(
        logic signed [CW_TB-1:0] a, logic signed [CW_TB-1:0] b, logic [TW_TB-1:0] t);
        longint diff;
        longint prod;
        diff = longint'(b) - longint'(a);
        prod = diff * longint'({47'b0, t});
        return CW_TB'(longint'(a) + (prod >>> 16));
    endfunction

    function automatic logic signed [CW_TB-1:0] reduce_axis(int axis, int n,
                                                            logic [TW_TB-1:0] t);
        logic signed [CW_TB-1:0] tmp [MAX_PTS];
        for (int i = 0; i < MAX_PTS; i++)
        begin
            tmp[i] = ctrl_pts[axis][i];
        end
        for (int r = 1; r < n; r++)
        begin
            for (int i = 0; i + r < n; i++)
            begin
                tmp[i] = lerp_floor(tmp[i], tmp[i + 1], t);
            end
        end
        return tmp[0];
    endfunction

    function automatic point_t curve_point(logic [TW_TB-1:0] t_raw);
        logic [TW_TB-1:0] t;
        int n;
        point_t p;
        t = (t_raw > bz_pkg::T_ONE) ? bz_pkg::T_ONE : t_raw;
        n = int'(pc_setting);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_PTS)
        begin
            n = MAX_PTS;
        end
        p.x = reduce_axis(0, n, t);
        p.y = reduce_axis(1, n, t);
        p.z = reduce_axis(2, n, t);
        return p;
    endfunction

    function automatic logic [CW_TB-1:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(3))
            0: return {{11{r[20]}}, r[20:0]};
            1:
            begin
                case (r[1:0])
                    2'd0: return 32'h7FFF_FFFF;
                    2'd1: return 32'h8000_0000;
                    2'd2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return r;
        endcase
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        c.kind = ($urandom_range(1) == 1) ? bz_pkg::KIND_EVAL : bz_pkg::KIND_WRITE;
        c.slot = 4'($urandom);
        c.pt.x = rand_coord();
        c.pt.y = rand_coord();
        c.pt.z = rand_coord();
        case ($urandom_range(7))
            0: c.t = '0;
            1: c.t = bz_pkg::T_ONE;
            2: c.t = TW_TB'($urandom_range(131071, 65537));
            default: c.t = TW_TB'($urandom_range(65536, 0));
        endcase
        return c;
    endfunction

    task automatic add_row(logic k, logic [3:0] s, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [TW_TB-1:0] t, logic known,
                           logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
        dir_row_t r;
        r.cmd.kind = k;
        r.cmd.slot = s;
        r.cmd.pt.x = x;
        r.cmd.pt.y = y;
        r.cmd.pt.z = z;
        r.cmd.t = t;
        r.known = known;
        r.want.x = ex;
        r.want.y = ey;
        r.want.z = ez;
        dir_rows.push_back(r);
    endtask

    task automatic apb_xfer(input logic wr, input logic [DW_TB-1:0] wdata,
                            output logic [DW_TB-1:0] rdata);
        logic rdy;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= PC_ADDR;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = pready;
            rdata = prdata;
            @(posedge clk);
        end while (!rdy);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drive_cmd(input cmd_t c, input logic known, input point_t want);
        logic acc;
        start <= 1'b1;
        kind <= c.kind;
        point_index <= c.slot;
        coord_x <= c.pt.x;
        coord_y <= c.pt.y;
        coord_z <= c.pt.z;
        param_t <= c.t;
        do
        begin
            @(negedge clk);
            acc = !busy;
            @(posedge clk);
        end while (!acc);
        if (c.kind == bz_pkg::KIND_WRITE)
        begin
            ctrl_pts[0][c.slot] = c.pt.x;
            ctrl_pts[1][c.slot] = c.pt.y;
            ctrl_pts[2][c.slot] = c.pt.z;
            n_writes++;
        end
        else
        begin
            pending_points.push_back(known ? want : curve_point(c.t));
            n_evals++;
        end
    endtask

    task automatic wait_idle();
        logic quiet;
        start <= 1'b0;
        @(posedge clk);
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        do
        begin
            @(negedge clk);
            quiet = !busy;
            @(posedge clk);
        end while (!quiet);
    endtask

    always @(negedge clk)
    begin : result_check
        point_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            n_results++;
            if (pending_points.size() == 0)
            begin
                flag_error($sformatf("curve point %h %h %h with no evaluation pending",
                                     curve_x, curve_y, curve_z));
            end
            else
            begin
                want = pending_points.pop_front();
                if (curve_x !== want.x)
                begin
                    flag_error($sformatf("curve_x expected %h got %h", want.x, curve_x));
                end
                if (curve_y !== want.y)
                begin
                    flag_error($sformatf("curve_y expected %h got %h", want.y, curve_y));
                end
                if (curve_z !== want.z)
                begin
                    flag_error($sformatf("curve_z expected %h got %h", want.z, curve_z));
                end
            end
        end
    end

    initial
    begin
        logic [DW_TB-1:0] rd;
        logic [DW_TB-1:0] wd;
        logic [PW_TB-1:0] pc_vals [N_PHASES];
        int idle_pcts [3];
        int idle_pct;
        point_t none;

        pc_vals = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd2, 5'd17, 5'd3, 5'd8, 5'd5, 5'd12, 5'd15, 5'd4};
        idle_pcts = '{0, 51, 18};
        none = '0;
        for (int a = 0; a < 3; a++)
        begin
            for (int i = 0; i < MAX_PTS; i++)
            begin
                ctrl_pts[a][i] = '0;
            end
        end

        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        start <= 1'b0;
        kind <= bz_pkg::KIND_WRITE;
        point_index <= '0;
        coord_x <= '0;
        coord_y <= '0;
        coord_z <= '0;
        param_t <= '0;

        // Curve of four points after reset: t at zero and at or above one land on the end points.
        add_row(bz_pkg::KIND_WRITE, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                17'h1FFFF, 1'b0, '0, '0, '0);
        add_row(bz_pkg::KIND_WRITE, 4'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                17'h00000, 1'b0, '0, '0, '0);
        add_row(bz_pkg::KIND_WRITE, 4'd2, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555,
                17'h0AAAA, 1'b0, '0, '0, '0);
        add_row(bz_pkg::KIND_WRITE, 4'd3, 32'hAAAA_AAAA, 32'h1234_5678, 32'h8000_0000,
                17'h15555, 1'b0, '0, '0, '0);
        add_row(bz_pkg::KIND_EVAL, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                17'h00000, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        add_row(bz_pkg::KIND_EVAL, 4'h0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                bz_pkg::T_ONE, 1'b1, 32'hAAAA_AAAA, 32'h1234_5678, 32'h8000_0000);
        add_row(bz_pkg::KIND_EVAL, 4'hA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000,
                17'h1FFFF, 1'b1, 32'hAAAA_AAAA, 32'h1234_5678, 32'h8000_0000);
        add_row(bz_pkg::KIND_EVAL, 4'h5, 32'h0, 32'h0, 32'h0, 17'h00001,
                1'b0, '0, '0, '0);
        add_row(bz_pkg::KIND_EVAL, 4'h3, 32'h0, 32'h0, 32'h0, 17'h0FFFF,
                1'b0, '0, '0, '0);
        add_row(bz_pkg::KIND_EVAL, 4'hC, 32'h0, 32'h0, 32'h0, 17'h08000,
                1'b0, '0, '0, '0);
        for (int i = 4; i < MAX_PTS; i++)
        begin
            add_row(bz_pkg::KIND_WRITE, 4'(i), 32'(i) << 16, -(32'(i) << 16),
                    (i % 2 == 1) ? 32'hAAAA_AAAA : 32'h5555_5555, TW_TB'(i * 4099),
                    1'b0, '0, '0, '0);
        end
        add_row(bz_pkg::KIND_EVAL, 4'h9, 32'h0, 32'h0, 32'h0, 17'h10001,
                1'b1, 32'hAAAA_AAAA, 32'h1234_5678, 32'h8000_0000);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_xfer(1'b0, '0, rd);
        if (rd[PW_TB-1:0] !== bz_pkg::PC_RESET)
        begin
            flag_error($sformatf("point_count after reset expected %h got %h",
                                 bz_pkg::PC_RESET, rd[PW_TB-1:0]));
        end
        pc_setting = bz_pkg::PC_RESET;

        foreach (dir_rows[i])
        begin
            drive_cmd(dir_rows[i].cmd, dir_rows[i].known, dir_rows[i].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_idle();
            wd = $urandom;
            wd[PW_TB-1:0] = pc_vals[p];
            apb_xfer(1'b1, wd, rd);
            pc_setting = pc_vals[p];
            apb_xfer(1'b0, '0, rd);
            if (rd[PW_TB-1:0] !== pc_setting)
            begin
                flag_error($sformatf("point_count readback expected %h got %h",
                                     pc_setting, rd[PW_TB-1:0]));
            end
            idle_pct = idle_pcts[p % 3];
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                while ($urandom_range(99) < idle_pct)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                end
                if ($urandom_range(99) < 2)
                begin
                    wait_idle();
                end
                drive_cmd(random_cmd(), 1'b0, none);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d control point writes and %0d curve evaluations over %0d",
                 n_writes, n_evals, N_PHASES + 1);
        $display("point count settings, with %0d curve points checked.", n_results);
        if (n_errors == 0 && pending_points.size() == 0)
        begin
            $display("bezier_de_casteljau_eval regression: pass");
        end
        else
        begin
            $display("Errors: %0d, evaluations still pending: %0d",
                     n_errors, pending_points.size());
            $display("bezier_de_casteljau_eval regression: fail");
        end
        $finish;
    end

endmodule

### bezier_de_casteljau_eval.f
rtl/bz_pkg.sv
rtl/bz_lane.sv
rtl/bz_datapath.sv
rtl/bz_ctrl.sv
rtl/bezier_de_casteljau_eval.sv
tb/bezier_de_casteljau_eval_tb.sv
